// ===== design/prs_pkg.sv =====
// Package of the paging record scheduler: record type, sequencer states,
// operation, result and register codes shared by all design files.
// No dependencies.
`default_nettype none

package prs_pkg;

   localparam int TMSI_W      = 48;
   localparam int SFN_W       = 10;
   localparam int GROUP_W     = 2;
   localparam int GROUP_SLOTS = 4;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // input operations
   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
   localparam logic [OP_W-1:0] OP_ATTACH  = 2'd2;

   // result kinds
   localparam logic KIND_SENT = 1'b0;
   localparam logic KIND_DROP = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DRX_SELECT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_OFFSET = 2'd1;

   localparam logic [1:0] DRX_SELECT_RESET   = 2'd2;
   localparam logic [7:0] FRAME_OFFSET_RESET = 8'd0;

   typedef struct packed {
      logic [TMSI_W-1:0]  tmsi;
      logic               domain;
      logic [GROUP_W-1:0] group;
   } prs_rec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_READ,
      ST_EVAL,
      ST_DRAIN
   } prs_state_type;

endpackage

`default_nettype wire

// ===== design/prs_if.sv =====
// Handshake channels of the paging record scheduler: request and response.
// Depends on prs_pkg.
`default_nettype none

interface prs_req_if;
   logic                        valid;
   logic                        ready;
   logic [prs_pkg::OP_W-1:0]    op;
   logic [prs_pkg::TMSI_W-1:0]  tmsi;
   logic                        core_domain;

   modport source (output valid, op, tmsi, core_domain, input ready);
   modport sink   (input valid, op, tmsi, core_domain, output ready);
endinterface

interface prs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [prs_pkg::TMSI_W-1:0]  rec_tmsi;
   logic                        rec_domain;
   logic [prs_pkg::GROUP_W-1:0] page_group;
   logic [prs_pkg::SFN_W-1:0]   frame_number;
   logic                        last;

   modport source (output valid, kind, rec_tmsi, rec_domain, page_group, frame_number, last,
                   input ready);
   modport sink   (input valid, kind, rec_tmsi, rec_domain, page_group, frame_number, last,
                   output ready);
endinterface

`default_nettype wire

// ===== design/prs_queue.sv =====
// Record store of the paging scheduler: one write port, one read port with
// registered read data. Depends on prs_pkg.
`default_nettype none

module prs_queue #(
   parameter int DEPTH = 64
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  wire prs_pkg::prs_rec_type        wr_data,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
   output      prs_pkg::prs_rec_type        rd_data
);
   import prs_pkg::*;

   prs_rec_type mem [DEPTH];
   prs_rec_type rd_data_ff;

   // write one record
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read one record, data valid the next cycle and held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/paging_record_scheduler.sv =====
// Paging record scheduler: request channel req_port (op, tmsi, core_domain),
// response channel rsp_port, and a plain write port csr_* for the DRX cycle
// select (index 0) and the paging frame offset (index 1).
// Enqueue words store a record at the tail of the queue; a full queue turns
// the enqueue into one drop word (kind 1, last 1). Attach words mark the
// group of the identity as listening. A tick word advances the frame number,
// checks the group match in the match state and, when a listening group
// matches and the queue is not empty, walks the stored queue one record at
// a time through the single read port of the record store: each record is
// read, then sorted into send or keep. The final held word is flushed at
// the end of the walk. Kept records are written back in order through the
// write port as the walk goes, so the queue is compacted toward the head.
// Each sent record is held one step so that the last flag can be set on the
// final word; the output register lets the next request be taken while a
// word still waits. A stalled receiver holds the walk at the next record to
// be sent. Reset (synchronous) empties the queue, clears the frame number and
// the listening groups, and loads the register defaults; the store itself
// needs no clearing since only entries below the fill count are read.
// Depends on prs_pkg, prs_if and prs_queue.
`default_nettype none

module paging_record_scheduler #(
   parameter int NUM_GROUPS   = 4,
   parameter int MAX_PER_PAGE = 32,
   parameter int QUEUE_DEPTH  = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   prs_req_if.sink                                 req_port,
   prs_rsp_if.source                               rsp_port,
   input  wire logic                               csr_write_enable,
   input  wire logic [prs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [prs_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import prs_pkg::*;

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int N_W    = $clog2(MAX_PER_PAGE + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
   localparam logic [N_W-1:0]   MAX_C   = N_W'(MAX_PER_PAGE);
   localparam logic [3:0]       NG_C    = 4'(NUM_GROUPS);
   localparam logic [1:0]       GMASK_C = 2'(NUM_GROUPS - 1);
   localparam bit               NG_POW2 = (NUM_GROUPS & (NUM_GROUPS - 1)) == 0;
   // slot spacing of the groups for each DRX cycle
   localparam logic [8:0] SLOT_0 = 9'(32 / NUM_GROUPS);
   localparam logic [8:0] SLOT_1 = 9'(64 / NUM_GROUPS);
   localparam logic [8:0] SLOT_2 = 9'(128 / NUM_GROUPS);
   localparam logic [8:0] SLOT_3 = 9'(256 / NUM_GROUPS);

   // group of an identity: low ten bits modulo the group count
   function automatic logic [GROUP_W-1:0] group_of(input logic [9:0] low);
      logic [3:0] s;
      if (NG_POW2) begin
         return low[1:0] & GMASK_C;
      end
      // three groups: 4 is 1 mod 3, so sum the base-4 digits and reduce
      s = 4'(low[1:0]) + 4'(low[3:2]) + 4'(low[5:4]) + 4'(low[7:6]) + 4'(low[9:8]);
      for (int i = 0; i < 5; i++) begin
         if (s >= NG_C) begin
            s = s - NG_C;
         end
      end
      return s[GROUP_W-1:0];
   endfunction

   prs_state_type state_ff, state_in;

   logic [1:0]             drx_sel_ff, drx_sel_in;
   logic [7:0]             offset_ff, offset_in;
   logic [SFN_W-1:0]       sfn_ff, sfn_in;
   logic [GROUP_SLOTS-1:0] listen_ff, listen_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ADDR_W-1:0]      rd_ff, rd_in;
   logic [CNT_W-1:0]       wr_ff, wr_in;
   logic [N_W-1:0]         n_ff, n_in;
   logic [GROUP_W-1:0]     grp_ff, grp_in;

   prs_rec_type            hold_rec_ff, hold_rec_in;
   logic                   hold_kind_ff, hold_kind_in;
   logic                   hold_valid_ff, hold_valid_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   prs_rec_type            rsp_rec_ff, rsp_rec_in;
   logic [SFN_W-1:0]       rsp_frame_ff, rsp_frame_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   prs_rec_type            mem_wr_data, mem_rd_data;

   logic                   req_fire, out_free;
   prs_rec_type            req_rec;
   logic [10:0]            phase_sum;
   logic [8:0]             phase, slot;
   logic                   match_found;
   logic [GROUP_W-1:0]     match_g;
   logic                   is_hit, eval_stall, scan_end;

   prs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_ff),
      .rd_data (mem_rd_data)
   );

   assign req_fire = req_port.valid && req_port.ready;
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   assign req_rec.tmsi   = req_port.tmsi;
   assign req_rec.domain = req_port.core_domain;
   assign req_rec.group  = group_of(req_port.tmsi[9:0]);

   // phase of the current frame within the DRX cycle
   assign phase_sum = {1'b0, sfn_ff} + 11'(offset_ff);
   assign phase     = phase_sum[8:0] & ((9'd32 << drx_sel_ff) - 9'd1);

   always_comb begin
      case (drx_sel_ff)
         2'd0:    slot = SLOT_0;
         2'd1:    slot = SLOT_1;
         2'd2:    slot = SLOT_2;
         default: slot = SLOT_3;
      endcase
   end

   // lowest listening group whose slot matches the phase
   always_comb begin
      match_found = 1'b0;
      match_g     = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (listen_ff[g] && phase == 9'(slot * g)) begin
            match_found = 1'b1;
            match_g     = GROUP_W'(g);
         end
      end
   end

   // walk status
   assign is_hit     = (mem_rd_data.group == grp_ff) && (n_ff < MAX_C);
   assign eval_stall = is_hit && hold_valid_ff && !out_free;
   assign scan_end   = (CNT_W'(rd_ff) + CNT_W'(1)) == count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_port.op == OP_TICK) begin
                  state_in = ST_MATCH;
               end else if (req_port.op == OP_ENQUEUE && count_ff >= DEPTH_C) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_MATCH: begin
            if (match_found && count_ff != '0) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!eval_stall) begin
               if (!scan_end) begin
                  state_in = ST_READ;
               end else if (hold_valid_ff || is_hit) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs of each state
   always_comb begin
      drx_sel_in    = drx_sel_ff;
      offset_in     = offset_ff;
      sfn_in        = sfn_ff;
      listen_in     = listen_ff;
      count_in      = count_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      n_in          = n_ff;
      grp_in        = grp_ff;
      hold_rec_in   = hold_rec_ff;
      hold_kind_in  = hold_kind_ff;
      hold_valid_in = hold_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[ADDR_W-1:0];
      mem_wr_data   = req_rec;
      mem_rd_en     = 1'b0;

      // configuration writes
      if (csr_write_enable) begin
         case (csr_index)
            REG_DRX_SELECT:   drx_sel_in = csr_write_data[1:0];
            REG_FRAME_OFFSET: offset_in  = csr_write_data;
            default:          ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_port.op)
                  OP_ENQUEUE: begin
                     if (count_ff < DEPTH_C) begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end else begin
                        hold_rec_in   = req_rec;
                        hold_kind_in  = KIND_DROP;
                        hold_valid_in = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     sfn_in = sfn_ff + SFN_W'(1);
                  end
                  OP_ATTACH: begin
                     listen_in = listen_ff | (GROUP_SLOTS'(1) << req_rec.group);
                  end
                  default: ;
               endcase
            end
         end
         ST_MATCH: begin
            grp_in = match_g;
            rd_in  = '0;
            wr_in  = '0;
            n_in   = '0;
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
         end
         ST_EVAL: begin
            if (!eval_stall) begin
               if (is_hit) begin
                  // flush the held word, hold the new one
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = hold_kind_ff;
                     rsp_rec_in   = hold_rec_ff;
                     rsp_frame_in = sfn_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_rec_in   = mem_rd_data;
                  hold_kind_in  = KIND_SENT;
                  hold_valid_in = 1'b1;
                  n_in          = n_ff + N_W'(1);
               end else begin
                  // keep: compact toward the head
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = wr_ff[ADDR_W-1:0];
                  mem_wr_data = mem_rd_data;
                  wr_in       = wr_ff + CNT_W'(1);
               end
               rd_in = rd_ff + ADDR_W'(1);
               if (scan_end) begin
                  count_in = is_hit ? wr_ff : wr_ff + CNT_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = hold_kind_ff;
               rsp_rec_in    = hold_rec_ff;
               rsp_frame_in  = sfn_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         drx_sel_ff    <= DRX_SELECT_RESET;
         offset_ff     <= FRAME_OFFSET_RESET;
         sfn_ff        <= '0;
         listen_ff     <= '0;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         drx_sel_ff    <= drx_sel_in;
         offset_ff     <= offset_in;
         sfn_ff        <= sfn_in;
         listen_ff     <= listen_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      rd_ff        <= rd_in;
      wr_ff        <= wr_in;
      n_ff         <= n_in;
      grp_ff       <= grp_in;
      hold_rec_ff  <= hold_rec_in;
      hold_kind_ff <= hold_kind_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_rec_ff   <= rsp_rec_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_port.ready        = (state_ff == ST_IDLE);
   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.kind         = rsp_kind_ff;
   assign rsp_port.rec_tmsi     = rsp_rec_ff.tmsi;
   assign rsp_port.rec_domain   = rsp_rec_ff.domain;
   assign rsp_port.page_group   = rsp_rec_ff.group;
   assign rsp_port.frame_number = rsp_frame_ff;
   assign rsp_port.last         = rsp_last_ff;

   // no word is held back once the block is idle
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff)
      else $error("held word left behind in idle");

   // compaction never overtakes the read pointer
   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> wr_ff <= CNT_W'(rd_ff))
      else $error("write pointer ahead of read pointer");

   // fill count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("record count beyond queue depth");

   // a stalled walk keeps the pending hit and the output word
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL && eval_stall |=> state_ff == ST_EVAL && rsp_valid_ff)
      else $error("walk moved on while the output was stalled");

   // a sent word is only ever loaded from a held word
   a_push_from_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && rsp_valid_in |-> hold_valid_ff)
      else $error("output loaded without a held word");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Testbench of the paging record scheduler: a directed table, then random
// scenarios, each response word checked against typed words or a predictor.
// Depends on prs_pkg, prs_if and paging_record_scheduler.

module testbench;
   import prs_pkg::*;

   localparam logic [OP_W-1:0]        OP_UNUSED      = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;
   localparam int QUEUE_DEPTH  = 64;
   localparam int MAX_PER_PAGE = 32;
   localparam int IDLE_PERCENT = 38;
   localparam int WALK_SETTLE  = 160;
   localparam int TARGET_ITEMS = 330;
   localparam int TARGET_WORDS = 48;
   localparam int HOLDOFF_LEN  = 400;

   typedef struct packed {
      logic               kind;
      logic [TMSI_W-1:0]  tmsi;
      logic               domain;
      logic [GROUP_W-1:0] group;
      logic [SFN_W-1:0]   sfn;
      logic               last;
   } page_word_type;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [TMSI_W-1:0] tmsi;
      logic              domain;
      int                typed_count;   // -1: take the predicted words
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   prs_req_if req_if();
   prs_rsp_if rsp_if();

   paging_record_scheduler dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_if),
      .rsp_port         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predicted state of the scheduler
   prs_rec_type            sched_queue[$];
   logic [SFN_W-1:0]       sched_sfn;
   logic [GROUP_SLOTS-1:0] sched_listening;
   logic [1:0]             sched_drx_select;
   logic [7:0]             sched_offset;

   page_word_type predicted_words[$];
   page_word_type expected_words[$];
   int            items_sent;
   int            words_predicted;
   int            error_count;
   int            idle_percent;
   int            holdoff_request;

   // directed rows: DRX select 0 (cycle 32) and offset 255 put group 0 on
   // frame 1 and group 1 on frame 9
   stim_row_type directed_rows[21] = '{
      '{OP_UNUSED,  48'hFFFF_FFFF_FFFF, 1'b1,  0},
      '{OP_ATTACH,  48'h0000_0000_0000, 1'b0,  0},
      '{OP_ATTACH,  48'hFFFF_FFFF_FFFF, 1'b0,  0},
      '{OP_ATTACH,  48'h0000_0000_0004, 1'b1,  0},
      '{OP_ENQUEUE, 48'h0000_0000_0000, 1'b0,  0},
      '{OP_ENQUEUE, 48'hFFFF_FFFF_FFFF, 1'b1,  0},
      '{OP_ENQUEUE, 48'h8000_0000_0400, 1'b1,  0},
      '{OP_ENQUEUE, 48'h0000_0000_0001, 1'b0,  0},
      '{OP_TICK,    48'h0000_0000_0000, 1'b0,  2},
      '{OP_TICK,    48'hFFFF_FFFF_FFFF, 1'b1,  0},
      '{OP_ATTACH,  48'h0000_0000_03FD, 1'b0,  0},
      '{OP_ENQUEUE, 48'hAAAA_AAAA_AAAA, 1'b1,  0},
      '{OP_ENQUEUE, 48'h5555_5555_5555, 1'b0,  0},
      '{OP_TICK,    48'h0000_0000_0000, 1'b0, -1},
      '{OP_TICK,    48'h0000_0000_0000, 1'b0, -1},
      '{OP_TICK,    48'h0000_0000_0000, 1'b0, -1},
      '{OP_TICK,    48'h0000_0000_0000, 1'b0, -1},
      '{OP_TICK,    48'h0000_0000_0000, 1'b0, -1},
      '{OP_TICK,    48'h0000_0000_0000, 1'b0, -1},
      '{OP_TICK,    48'h0000_0000_0000, 1'b0,  2},
      '{OP_TICK,    48'h0000_0000_0000, 1'b0, -1}
   };

   page_word_type typed_words[4] = '{
      '{KIND_SENT, 48'h0000_0000_0000, 1'b0, 2'd0, 10'd1, 1'b0},
      '{KIND_SENT, 48'h8000_0000_0400, 1'b1, 2'd0, 10'd1, 1'b1},
      '{KIND_SENT, 48'h0000_0000_0001, 1'b0, 2'd1, 10'd9, 1'b0},
      '{KIND_SENT, 48'h5555_5555_5555, 1'b0, 2'd1, 10'd9, 1'b1}
   };

   function automatic logic [GROUP_W-1:0] group_of_tmsi(input logic [TMSI_W-1:0] id);
      return GROUP_W'(id[SFN_W-1:0] % GROUP_SLOTS);
   endfunction

   function automatic logic [TMSI_W-1:0] random_tmsi();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      return bits[TMSI_W-1:0];
   endfunction

   function automatic logic [TMSI_W-1:0] tmsi_in_group(input logic [GROUP_W-1:0] g);
      logic [TMSI_W-1:0] id;
      id = random_tmsi();
      return {id[TMSI_W-1:GROUP_W], g};
   endfunction

   // lowest listening group whose paging frame falls on this frame, or -1
   function automatic int served_group(input logic [SFN_W-1:0] sfn);
      int cycle_len;
      int phase;
      cycle_len = 32 << sched_drx_select;
      phase = (int'(sfn) + int'(sched_offset)) % cycle_len;
      for (int g = 0; g < GROUP_SLOTS; g++)
         if (sched_listening[g] && phase == (cycle_len / GROUP_SLOTS) * g)
            return g;
      return -1;
   endfunction

   // advance the predicted state by one request word, collect its responses
   task automatic predict_paging(input logic [OP_W-1:0] op, input logic [TMSI_W-1:0] id,
                                 input logic dom);
      prs_rec_type   rec;
      prs_rec_type   kept[$];
      page_word_type w;
      int            g;
      int            sent;
      predicted_words.delete();
      rec = '{tmsi: id, domain: dom, group: group_of_tmsi(id)};
      case (op)
         OP_ENQUEUE: begin
            if (sched_queue.size() >= QUEUE_DEPTH) begin
               w = '{kind: KIND_DROP, tmsi: id, domain: dom, group: rec.group,
                     sfn: sched_sfn, last: 1'b1};
               predicted_words.push_back(w);
            end else begin
               sched_queue.push_back(rec);
            end
         end
         OP_ATTACH: begin
            sched_listening[rec.group] = 1'b1;
         end
         OP_TICK: begin
            sched_sfn = sched_sfn + 1'b1;
            g = served_group(sched_sfn);
            if (g >= 0) begin
               sent = 0;
               // pull up to a page of the group's records, keep the rest in order
               foreach (sched_queue[i]) begin
                  if (sched_queue[i].group == g && sent < MAX_PER_PAGE) begin
                     w = '{kind: KIND_SENT, tmsi: sched_queue[i].tmsi,
                           domain: sched_queue[i].domain, group: sched_queue[i].group,
                           sfn: sched_sfn, last: 1'b0};
                     predicted_words.push_back(w);
                     sent++;
                  end else begin
                     kept.push_back(sched_queue[i]);
                  end
               end
               sched_queue = kept;
               if (sent > 0) begin
                  w = predicted_words.pop_back();
                  w.last = 1'b1;
                  predicted_words.push_back(w);
               end
            end
         end
         default: ;
      endcase
      words_predicted += predicted_words.size();
   endtask

   // offer one request word after a random gap, predict it once taken
   task automatic send_word(input logic [OP_W-1:0] op, input logic [TMSI_W-1:0] id,
                            input logic dom);
      while ($urandom_range(99) < idle_percent) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.op          <= op;
      req_if.tmsi        <= id;
      req_if.core_domain <= dom;
      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);
      predict_paging(op, id, dom);
      if (op != OP_UNUSED)
         items_sent++;
   endtask

   task automatic offer_word(input logic [OP_W-1:0] op, input logic [TMSI_W-1:0] id,
                             input logic dom);
      send_word(op, id, dom);
      foreach (predicted_words[i])
         expected_words.push_back(predicted_words[i]);
   endtask

   // hold the request side until every response is in and the walk is done
   task automatic drain_block();
      req_if.valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (WALK_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         REG_DRX_SELECT:   sched_drx_select = data[1:0];
         REG_FRAME_OFFSET: sched_offset     = data;
         default: ;
      endcase
   endtask

   // load both registers; spare indexes get junk that must change nothing
   task automatic configure(input logic [1:0] drx, input logic [7:0] offset);
      write_reg(REG_DRX_SELECT, {6'($urandom_range(63)), drx});
      write_reg($urandom_range(1) ? REG_SPARE_LOW : REG_SPARE_HIGH, 8'($urandom_range(255)));
      write_reg(REG_FRAME_OFFSET, offset);
      csr_write_enable <= 1'b0;
   endtask

   // fill the queue from two groups, then overflow it
   task automatic fill_queue();
      logic [GROUP_W-1:0] ga;
      logic [GROUP_W-1:0] gb;
      ga = GROUP_W'($urandom_range(GROUP_SLOTS - 1));
      gb = GROUP_W'($urandom_range(GROUP_SLOTS - 1));
      while (sched_queue.size() < QUEUE_DEPTH)
         offer_word(OP_ENQUEUE, tmsi_in_group($urandom_range(1) ? ga : gb), $urandom_range(1));
      repeat (3) offer_word(OP_ENQUEUE, random_tmsi(), $urandom_range(1));
   endtask

   // load one group, attach it, tick up to its paging frame and page it;
   // with squeeze the receiver holds off over the page
   task automatic page_burst(input bit squeeze);
      int                 counts[GROUP_SLOTS];
      logic [GROUP_W-1:0] g;
      int                 fill;
      g = GROUP_W'($urandom_range(GROUP_SLOTS - 1));
      if (squeeze) begin
         foreach (counts[i])
            counts[i] = 0;
         foreach (sched_queue[i])
            counts[sched_queue[i].group]++;
         foreach (counts[i])
            if (counts[i] > counts[g])
               g = GROUP_W'(i);
      end
      fill = $urandom_range(8, 24);
      repeat (fill)
         offer_word(OP_ENQUEUE,
                    tmsi_in_group($urandom_range(9) < 7 ? g : GROUP_W'($urandom_range(3))),
                    $urandom_range(1));
      offer_word(OP_ATTACH, tmsi_in_group(g), $urandom_range(1));
      while (served_group(sched_sfn + 1'b1) != int'(g))
         offer_word(OP_TICK, random_tmsi(), $urandom_range(1));
      if (squeeze)
         holdoff_request = HOLDOFF_LEN;
      offer_word(OP_TICK, random_tmsi(), $urandom_range(1));
      repeat (4) offer_word(OP_ENQUEUE, random_tmsi(), $urandom_range(1));
   endtask

   task automatic mixed_traffic(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 40)
            offer_word(OP_ENQUEUE, random_tmsi(), $urandom_range(1));
         else if (pick < 85)
            offer_word(OP_TICK, random_tmsi(), $urandom_range(1));
         else if (pick < 95)
            offer_word(OP_ATTACH, random_tmsi(), $urandom_range(1));
         else
            offer_word(OP_UNUSED, random_tmsi(), $urandom_range(1));
      end
   endtask

   initial begin : clock_gen
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // request side: reset, directed table, random scenarios, verdict
   initial begin : stimulus
      int typed_next;
      int phase;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.op          <= OP_ENQUEUE;
      req_if.tmsi        <= '0;
      req_if.core_domain <= 1'b0;
      csr_write_enable   <= 1'b0;
      csr_index          <= REG_DRX_SELECT;
      csr_write_data     <= '0;
      idle_percent     = IDLE_PERCENT;
      holdoff_request  = 0;
      items_sent       = 0;
      words_predicted  = 0;
      error_count      = 0;
      sched_sfn        = '0;
      sched_listening  = '0;
      sched_drx_select = DRX_SELECT_RESET;
      sched_offset     = FRAME_OFFSET_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(2'd0, 8'd255);
      typed_next = 0;
      foreach (directed_rows[r]) begin
         send_word(directed_rows[r].op, directed_rows[r].tmsi, directed_rows[r].domain);
         if (directed_rows[r].typed_count < 0) begin
            foreach (predicted_words[i])
               expected_words.push_back(predicted_words[i]);
         end else begin
            repeat (directed_rows[r].typed_count) begin
               expected_words.push_back(typed_words[typed_next]);
               typed_next++;
            end
         end
      end
      drain_block();

      phase = 0;
      while ((items_sent < TARGET_ITEMS || words_predicted < TARGET_WORDS) && phase < 40) begin
         case (phase)
            0: begin
               configure(2'd3, 8'd0);
               fill_queue();
            end
            1: begin
               configure(2'd0, 8'($urandom_range(255)));
               page_burst(1'b1);
            end
            2: begin
               idle_percent = 0;
               configure(2'd1, 8'd128);
               mixed_traffic(50);
            end
            default: begin
               if (phase % 2) begin
                  configure(2'($urandom_range(1)), 8'($urandom_range(255)));
                  page_burst(1'b0);
               end else begin
                  configure(2'($urandom_range(3)), 8'($urandom_range(255)));
                  mixed_traffic(40);
               end
            end
         endcase
         idle_percent = IDLE_PERCENT;
         drain_block();
         phase++;
      end

      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // response side: check each taken word, then pick ready for the next edge
   initial begin : response_check
      page_word_type got;
      page_word_type want;
      int            stall_left;
      rsp_if.ready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got = '{kind: rsp_if.kind, tmsi: rsp_if.rec_tmsi, domain: rsp_if.rec_domain,
                    group: rsp_if.page_group, sfn: rsp_if.frame_number, last: rsp_if.last};
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word: expected none, got kind %0d tmsi %h dom %0d",
                        $time, got.kind, got.tmsi, got.domain,
                        " group %0d sfn %0d last %0d", got.group, got.sfn, got.last);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (got.kind !== want.kind || got.tmsi !== want.tmsi ||
                   got.domain !== want.domain || got.group !== want.group ||
                   got.sfn !== want.sfn || got.last !== want.last) begin
                  $display("%0t: word mismatch: expected kind %0d tmsi %h dom %0d",
                           $time, want.kind, want.tmsi, want.domain,
                           " group %0d sfn %0d last %0d", want.group, want.sfn, want.last,
                           ", got kind %0d tmsi %h dom %0d", got.kind, got.tmsi, got.domain,
                           " group %0d sfn %0d last %0d", got.group, got.sfn, got.last);
                  error_count++;
               end
            end
         end
         // take a hold-off request, then count it down here
         if (holdoff_request > 0) begin
            stall_left = holdoff_request;
            holdoff_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= idle_percent);
         end
      end
   end

   initial begin : watchdog
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/prs_pkg.sv
design/prs_if.sv
design/prs_queue.sv
design/paging_record_scheduler.sv
sim/testbench.sv
